// ===== hdl/assert_macros.svh =====
// Assertion macros for the memory bank mapper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define ASSERT_ON_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("memory bank mapper assertion failed");

// Check an implication on every rising edge while reset is released.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  `ASSERT_ON_CLK(lbl, clk, rstn, (ante) |-> (cons))

`endif

// ===== hdl/mbm_pkg.sv =====
// Types, codes and constants of the memory bank mapper.
package mbm_pkg;

  // Bus event codes
  localparam logic [2:0] FUNC_MEM_RD    = 3'd0;
  localparam logic [2:0] FUNC_MEM_WR    = 3'd1;
  localparam logic [2:0] FUNC_PORT_WR   = 3'd2;
  localparam logic [2:0] FUNC_INSN_BEG  = 3'd3;
  localparam logic [2:0] FUNC_INSN_END  = 3'd4;

  // Physical store codes
  localparam logic [2:0] ST_NONE = 3'd0;
  localparam logic [2:0] ST_MAIN = 3'd1;
  localparam logic [2:0] ST_ROM2 = 3'd2;
  localparam logic [2:0] ST_BANK = 3'd3;
  localparam logic [2:0] ST_CPM  = 3'd4;
  localparam logic [2:0] ST_DRAM = 3'd5;
  localparam logic [2:0] ST_DROM = 3'd6;
  localparam logic [2:0] ST_BOOT = 3'd7;

  // Configuration register indexes (byte address 4*index)
  localparam logic [1:0] REG_MODEL_128  = 2'd0;
  localparam logic [1:0] REG_BOOT_ROM   = 2'd1;
  localparam logic [1:0] REG_DISK_IF    = 2'd2;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Port decode constants
  localparam logic [15:0] BANK_PORT_MASK = 16'h8002;
  localparam logic [15:0] CONF_PORT_MASK = 16'h0081;
  localparam logic [7:0]  CPM_PORT_CLR   = 8'hC5;
  localparam logic [7:0]  CPM_PORT_SET   = 8'hC7;
  localparam logic [7:0]  LOW_RAM_PORT   = 8'h7E;

  // Disk shadow ROM trap addresses
  localparam logic [15:0] DROM_TRAP_A    = 16'h0008;
  localparam logic [15:0] DROM_TRAP_B    = 16'h1708;
  localparam logic [15:0] DROM_EXIT      = 16'h0700;

  // Bank latch bit positions
  localparam int unsigned BANK_ROM_BIT  = 4;
  localparam int unsigned BANK_LOCK_BIT = 5;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
  } req_t;

  typedef struct packed {
    logic [2:0]  target_store;
    logic [15:0] store_offset;
    logic [2:0]  ram_bank;
    logic        write_enable;
    logic        alt_screen;
  } rsp_t;

  typedef struct packed {
    logic model_is_128;
    logic boot_rom_present;
    logic disk_interface_present;
  } cfg_t;

  typedef struct packed {
    logic [5:0] bank_latch;
    logic [7:0] config_latch;
    logic       config_locked;
    logic       cpm_a13_flag;
    logic [1:0] low_ram_paging;
    logic       disk_rom_paged;
    logic       screen_sel;
  } paging_t;

endpackage

// ===== hdl/memory_bank_mapper.sv =====
// Top level of the memory bank mapper: request and result registers, paging state, APB port.
//
//   channel   direction  handshake                      payload
//   request   in         in_valid_i / in_ready_o        in_req_i   (mbm_pkg::req_t)
//   result    out        out_valid_o / out_ready_i      out_rsp_o  (mbm_pkg::rsp_t)
//   config    in         psel/penable/pwrite, pready=1  paddr, pwdata, prdata
//
// One request per cycle while the result register is not stalled: a request is
// registered in the request register, decoded by mbm_decode and written to the
// result register, from which its result is offered. Paging latches update as the
// request moves to the result register.
// Reset clears the latches and configuration bits; no clearing pass is needed.
// A stalled result register holds the request register, which keeps accepting while empty.
module memory_bank_mapper (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mbm_pkg::req_t                 in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mbm_pkg::rsp_t                 out_rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbm_pkg::PADDR_W-1:0]   paddr,
  input  logic [mbm_pkg::PDATA_W-1:0]   pwdata,
  output logic [mbm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import mbm_pkg::*;

  cfg_t    cfg_q;
  paging_t pg_q;
  paging_t pg_d;
  req_t    req_q;
  rsp_t    rsp_d;
  rsp_t    rsp_q;
  logic    req_valid_q;
  logic    out_valid_q;
  logic    in_fire;
  logic    adv;
  logic    req_fire;
  logic    cfg_wr;
  logic [1:0] reg_idx;
  logic       bank_locked;
  logic       conf_lock;
  logic [7:0] conf_val;
  logic       drom_page_in;
  logic       out_wr;
  logic       out_st_writable;

  mbm_decode u_decode (
    .cfg_i (cfg_q),
    .cur_i (pg_q),
    .req_i (req_q),
    .rsp_o (rsp_d),
    .nxt_o (pg_d)
  );

  assign adv        = !out_valid_q || out_ready_i;
  assign req_fire   = req_valid_q && adv;
  assign in_ready_o = !req_valid_q || adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      pg_q        <= '0;
    end else begin
      req_valid_q <= in_fire || (req_valid_q && !adv);
      out_valid_q <= req_fire || (out_valid_q && !out_ready_i);
      if (req_fire) begin
        pg_q <= pg_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_req_i;
    end
    if (req_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODEL_128: cfg_q.model_is_128           <= pwdata[0];
        REG_BOOT_ROM:  cfg_q.boot_rom_present       <= pwdata[0];
        REG_DISK_IF:   cfg_q.disk_interface_present <= pwdata[0];
        default:       cfg_q                        <= cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_MODEL_128: prdata[0] = cfg_q.model_is_128;
      REG_BOOT_ROM:  prdata[0] = cfg_q.boot_rom_present;
      REG_DISK_IF:   prdata[0] = cfg_q.disk_interface_present;
      default:       prdata    = '0;
    endcase
  end

  assign bank_locked     = pg_q.bank_latch[BANK_LOCK_BIT];
  assign conf_lock       = pg_q.config_locked;
  assign conf_val        = pg_q.config_latch;
  assign drom_page_in    = req_fire && pg_d.disk_rom_paged && !pg_q.disk_rom_paged;
  assign out_wr          = out_valid_q && rsp_q.write_enable;
  assign out_st_writable = (rsp_q.target_store != ST_NONE) && (rsp_q.target_store != ST_ROM2) &&
                           (rsp_q.target_store != ST_DROM) && (rsp_q.target_store != ST_BOOT);

`include "assert_macros.svh"

  // A locked bank latch never changes.
  `ASSERT_IMPL(a_bank_lock_holds, clk_i, rst_ni, bank_locked, ##1 $stable(pg_q.bank_latch))
  // A locked config latch stays locked and unchanged.
  `ASSERT_IMPL(a_conf_lock_holds, clk_i, rst_ni, conf_lock, ##1 (conf_lock && $stable(conf_val)))
  // The disk ROM pages in only with the interface attached.
  `ASSERT_IMPL(a_drom_needs_if, clk_i, rst_ni, drom_page_in, cfg_q.disk_interface_present)
  // Writes never land in ROM or nowhere.
  `ASSERT_IMPL(a_no_rom_write, clk_i, rst_ni, out_wr, out_st_writable)
  // Backpressure reaches the input only when the request register is full.
  `ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !req_valid_q, in_ready_o)

endmodule

// ===== hdl/mbm_decode.sv =====
// Address map decode and paging latch update for one bus event.
module mbm_decode (
  input  mbm_pkg::cfg_t    cfg_i,
  input  mbm_pkg::paging_t cur_i,
  input  mbm_pkg::req_t    req_i,
  output mbm_pkg::rsp_t    rsp_o,
  output mbm_pkg::paging_t nxt_o
);
  import mbm_pkg::*;

  logic [15:0] a;
  logic [7:0]  d;
  logic [7:0]  port_lo;
  logic        is_mem;
  logic [2:0]  st;
  logic [15:0] off;
  logic [2:0]  bank;
  logic        wr;
  logic        low_ram;

  assign a       = req_i.bus_address;
  assign d       = req_i.bus_data;
  assign port_lo = a[7:0];
  assign is_mem  = (req_i.func == FUNC_MEM_RD) || (req_i.func == FUNC_MEM_WR);

  // Memory map
  always_comb begin
    st   = ST_MAIN;
    off  = a;
    bank = 3'd0;
    wr   = 1'b0;
    if (cfg_i.model_is_128) begin
      if (a[15:14] == 2'd0) begin
        st = cur_i.bank_latch[BANK_ROM_BIT] ? ST_ROM2 : ST_MAIN;
      end else begin
        st  = ST_BANK;
        off = {2'b00, a[13:0]};
        wr  = 1'b1;
        unique case (a[15:14])
          2'd1:    bank = 3'd5;
          2'd2:    bank = 3'd2;
          default: bank = cur_i.bank_latch[2:0];
        endcase
      end
    end else if (cfg_i.boot_rom_present) begin
      priority if (a[15:14] == 2'd0) begin
        priority if (cur_i.config_latch[1]) begin
          st = ST_CPM;
          wr = 1'b1;
        end else if (cur_i.disk_rom_paged) begin
          st = a[13] ? ST_DRAM : ST_DROM;
          wr = a[13];
        end else begin
          st = cur_i.config_latch[0] ? ST_BOOT : ST_MAIN;
        end
      end else if (a[15:13] == 3'b110 && cur_i.cpm_a13_flag) begin
        off = a | 16'h2000;
        wr  = 1'b1;
      end else if (a[15:13] == 3'b111 && cur_i.config_latch[1]) begin
        st  = cur_i.config_latch[0] ? ST_BOOT : ST_MAIN;
        off = {3'b001, a[12:0]};
      end else begin
        wr = 1'b1;
      end
    end else begin
      priority if (a[15:14] != 2'd0) begin
        wr = 1'b1;
      end else if (cur_i.low_ram_paging[1]) begin
        st = ST_DRAM;
        wr = 1'b1;
      end else if (cur_i.low_ram_paging[0]) begin
        st = ST_CPM;
        wr = 1'b1;
      end else if (cur_i.disk_rom_paged) begin
        st = a[13] ? ST_DRAM : ST_DROM;
        wr = a[13];
      end else begin
        st = ST_MAIN;
      end
    end
  end

  assign low_ram = cfg_i.boot_rom_present ? cur_i.config_latch[1]
                                          : (cur_i.low_ram_paging != 2'd0);

  // Latch updates
  always_comb begin
    nxt_o = cur_i;
    unique case (req_i.func)
      FUNC_PORT_WR: begin
        if (cfg_i.model_is_128 && ((a & BANK_PORT_MASK) == 16'h0000) &&
            !cur_i.bank_latch[BANK_LOCK_BIT]) begin
          nxt_o.bank_latch = d[5:0];
          nxt_o.screen_sel = d[3];
        end
        if (cfg_i.boot_rom_present) begin
          priority if ((a & CONF_PORT_MASK) == 16'h0000) begin
            if (!cur_i.config_locked) begin
              nxt_o.config_latch  = d;
              nxt_o.config_locked = d[2];
              nxt_o.screen_sel    = d[3];
            end
          end else if (port_lo == CPM_PORT_CLR || port_lo == CPM_PORT_SET) begin
            nxt_o.cpm_a13_flag = (port_lo == CPM_PORT_SET);
          end else begin
            nxt_o.cpm_a13_flag = cur_i.cpm_a13_flag;
          end
        end else if (!cfg_i.model_is_128 && port_lo == LOW_RAM_PORT) begin
          nxt_o.low_ram_paging = d[1:0] & {cfg_i.disk_interface_present, 1'b1};
        end
      end
      FUNC_INSN_BEG: begin
        if (cfg_i.disk_interface_present && !cur_i.disk_rom_paged && !low_ram &&
            (a == DROM_TRAP_A || a == DROM_TRAP_B)) begin
          nxt_o.disk_rom_paged = 1'b1;
        end
      end
      FUNC_INSN_END: begin
        if (cur_i.disk_rom_paged && a == DROM_EXIT) begin
          nxt_o.disk_rom_paged = 1'b0;
        end
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

  always_comb begin
    rsp_o.target_store = is_mem ? st : ST_NONE;
    rsp_o.store_offset = is_mem ? off : 16'h0000;
    rsp_o.ram_bank     = is_mem ? bank : 3'd0;
    rsp_o.write_enable = (req_i.func == FUNC_MEM_WR) && wr;
    rsp_o.alt_screen   = nxt_o.screen_sel;
  end

endmodule
